// ===== rtl/svb_pkg.sv =====
// ----------------------------------------------------------------------------
// svb_pkg: shared types and helpers for the velocity boundary block
// Value width, cell class codes, side kind codes, register indexes,
// request/result/register bundles and the saturating arithmetic helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svb_pkg;

   localparam int VALUE_BITS    = 32;
   localparam int FLAG_BITS     = 5;
   localparam int KIND_BITS     = 3;
   localparam int KINDS_BITS    = 12;
   localparam int CSR_ADDR_BITS = 3;

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [FLAG_BITS-1:0]         flags_type;
   typedef logic [KIND_BITS-1:0]         kind_type;
   typedef logic [CSR_ADDR_BITS-1:0]     csr_addr_type;

   localparam value_type VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam value_type VALUE_ZERO = '0;

   // cell class bits
   localparam int FLUID_BIT = 4;
   localparam int NORTH_BIT = 0;
   localparam int EAST_BIT  = 3;

   // obstacle and domain boundary codes (fluid bit clear)
   localparam flags_type CODE_N      = 5'b00001;
   localparam flags_type CODE_E      = 5'b01000;
   localparam flags_type CODE_S      = 5'b00010;
   localparam flags_type CODE_W      = 5'b00100;
   localparam flags_type CODE_NE     = 5'b01001;
   localparam flags_type CODE_SE     = 5'b01010;
   localparam flags_type CODE_SW     = 5'b00110;
   localparam flags_type CODE_NW     = 5'b00101;
   localparam flags_type CODE_LEFT   = 5'b00111;
   localparam flags_type CODE_RIGHT  = 5'b01011;
   localparam flags_type CODE_BOTTOM = 5'b01110;
   localparam flags_type CODE_TOP    = 5'b01101;

   // side kinds
   localparam kind_type KIND_NOSLIP  = 3'd1;
   localparam kind_type KIND_SLIP    = 3'd2;
   localparam kind_type KIND_OUTFLOW = 3'd3;
   localparam kind_type KIND_INFLOW  = 3'd4;

   localparam int KIND_LEFT_LSB   = 0;
   localparam int KIND_RIGHT_LSB  = 3;
   localparam int KIND_BOTTOM_LSB = 6;
   localparam int KIND_TOP_LSB    = 9;

   // register indexes
   localparam csr_addr_type REG_BOUNDARY_KINDS = 3'd0;
   localparam csr_addr_type REG_U_LEFT_WALL    = 3'd1;
   localparam csr_addr_type REG_U_BOTTOM_WALL  = 3'd2;
   localparam csr_addr_type REG_U_TOP_WALL     = 3'd3;
   localparam csr_addr_type REG_V_LEFT_WALL    = 3'd4;
   localparam csr_addr_type REG_V_RIGHT_WALL   = 3'd5;
   localparam csr_addr_type REG_V_BOTTOM_WALL  = 3'd6;

   typedef struct packed {
      flags_type cell_flags;
      value_type mid_u;
      value_type mid_v;
      value_type left_v;
      value_type right_u;
      value_type right_v;
      value_type bottom_u;
      value_type top_u;
      value_type top_v;
   } req_type;

   typedef struct packed {
      value_type new_u;
      value_type new_v;
   } rsp_type;

   typedef struct packed {
      logic [KINDS_BITS-1:0] boundary_kinds;
      value_type             u_left_wall;
      value_type             u_bottom_wall;
      value_type             u_top_wall;
      value_type             v_left_wall;
      value_type             v_right_wall;
      value_type             v_bottom_wall;
   } csr_type;

   // negate, saturating the most negative value to the most positive
   function automatic value_type neg_sat(value_type x);
      if (x == VALUE_MIN) begin
         return VALUE_MAX;
      end
      return -x;
   endfunction

   // 2*w - n computed exactly, then saturated to the value range
   function automatic value_type twice_minus(value_type w, value_type n);
      logic [VALUE_BITS+1:0] t;
      logic [2:0]            top3;
      t    = {w[VALUE_BITS-1], w, 1'b0} - {{2{n[VALUE_BITS-1]}}, n};
      top3 = t[VALUE_BITS+1:VALUE_BITS-1];
      if (top3 == 3'b000 || top3 == 3'b111) begin
         return value_type'(t[VALUE_BITS-1:0]);
      end
      if (t[VALUE_BITS+1]) begin
         return VALUE_MIN;
      end
      return VALUE_MAX;
   endfunction

endpackage

// ===== rtl/staggered_velocity_boundary.sv =====
// ----------------------------------------------------------------------------
// staggered_velocity_boundary: boundary rule for a staggered-grid flow solver
// Throughput: one request per cycle while the result is not stalled; an input
// register and a result register with the rule between them, so a stalled
// result still lets one more request in.
// Reset (synchronous, active high) empties both stages and clears all
// configuration registers to zero. The configuration port is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module staggered_velocity_boundary (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [4:0]            req_cell_flags,
   input  svb_pkg::value_type    req_mid_u,
   input  svb_pkg::value_type    req_mid_v,
   input  svb_pkg::value_type    req_left_v,
   input  svb_pkg::value_type    req_right_u,
   input  svb_pkg::value_type    req_right_v,
   input  svb_pkg::value_type    req_bottom_u,
   input  svb_pkg::value_type    req_top_u,
   input  svb_pkg::value_type    req_top_v,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output svb_pkg::value_type    rsp_new_u,
   output svb_pkg::value_type    rsp_new_v,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  svb_pkg::csr_addr_type csr_index,
   input  svb_pkg::value_type    csr_wdata
);
   import svb_pkg::*;

   // input stage
   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type req_ff;
   req_type req_in;

   // result stage
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic    s1_load;
   logic    s2_load;
   logic    req_accept;
   csr_type csr;

   // Configuration: always take writes; the user must write only while the block is idle (not enforced here).
   assign csr_ready = 1'b1;

   svb_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .csr      (csr)
   );

   // Bundle the request fields.
   always_comb begin
      req_in.cell_flags = req_cell_flags;
      req_in.mid_u      = req_mid_u;
      req_in.mid_v      = req_mid_v;
      req_in.left_v     = req_left_v;
      req_in.right_u    = req_right_u;
      req_in.right_v    = req_right_v;
      req_in.bottom_u   = req_bottom_u;
      req_in.top_u      = req_top_u;
      req_in.top_v      = req_top_v;
   end

   // Advance the result stage when it is empty or its result is taken;
   // advance the input stage when it is empty or moves on to the result stage.
   assign s2_load    = !rsp_valid_ff || !rsp_stall;
   assign s1_load    = !s1_valid_ff || s2_load;
   assign req_stall  = !s1_load;
   assign req_accept = req_valid && s1_load;

   assign s1_valid_in  = s1_load ? req_valid : s1_valid_ff;
   assign rsp_valid_in = s2_load ? s1_valid_ff : rsp_valid_ff;

   // Apply the boundary rule to the held request.
   svb_rule u_rule (
      .req (req_ff),
      .csr (csr),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on advance, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_in;
      end
      if (s2_load && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_new_u = rsp_ff.new_u;
   assign rsp_new_v = rsp_ff.new_v;

`ifndef SYNTH
   // Stall only when the input stage holds a request that cannot move on.
   a_stall_needs_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with empty input stage");

   // An accepted request lands in the input stage.
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted request lost");

   // A held request that advances produces a result next cycle.
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_load) |=> rsp_valid_ff)
      else $error("request did not reach result stage");

   // Reset empties both stages.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

// ===== rtl/svb_csr.sv =====
// ----------------------------------------------------------------------------
// svb_csr: configuration registers
// Side kinds and wall/inflow velocities, written one per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svb_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  svb_pkg::csr_addr_type wr_index,
   input  svb_pkg::value_type   wr_data,
   output svb_pkg::csr_type     csr
);
   import svb_pkg::*;

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_BOUNDARY_KINDS: csr_in.boundary_kinds = wr_data[KINDS_BITS-1:0];
            REG_U_LEFT_WALL:    csr_in.u_left_wall    = wr_data;
            REG_U_BOTTOM_WALL:  csr_in.u_bottom_wall  = wr_data;
            REG_U_TOP_WALL:     csr_in.u_top_wall     = wr_data;
            REG_V_LEFT_WALL:    csr_in.v_left_wall    = wr_data;
            REG_V_RIGHT_WALL:   csr_in.v_right_wall   = wr_data;
            REG_V_BOTTOM_WALL:  csr_in.v_bottom_wall  = wr_data;
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

// ===== rtl/svb_rule.sv =====
// ----------------------------------------------------------------------------
// svb_rule: per-cell boundary rule
// Select the new (u, v) from the cell class, the neighbors and the side kind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svb_rule (
   input  svb_pkg::req_type req,
   input  svb_pkg::csr_type csr,
   output svb_pkg::rsp_type rsp
);
   import svb_pkg::*;

   kind_type kind_left;
   kind_type kind_right;
   kind_type kind_bottom;
   kind_type kind_top;

   assign kind_left   = csr.boundary_kinds[KIND_LEFT_LSB   +: KIND_BITS];
   assign kind_right  = csr.boundary_kinds[KIND_RIGHT_LSB  +: KIND_BITS];
   assign kind_bottom = csr.boundary_kinds[KIND_BOTTOM_LSB +: KIND_BITS];
   assign kind_top    = csr.boundary_kinds[KIND_TOP_LSB    +: KIND_BITS];

   always_comb begin
      rsp.new_u = req.mid_u;
      rsp.new_v = req.mid_v;
      if (req.cell_flags[FLUID_BIT]) begin
         // fluid next to an obstacle: zero the closed face, north first
         if (!req.cell_flags[NORTH_BIT]) begin
            rsp.new_v = VALUE_ZERO;
         end else if (!req.cell_flags[EAST_BIT]) begin
            rsp.new_u = VALUE_ZERO;
         end
      end else begin
         unique case (req.cell_flags)
            CODE_N: begin
               rsp.new_u = neg_sat(req.top_u);
               rsp.new_v = VALUE_ZERO;
            end
            CODE_E: begin
               rsp.new_u = VALUE_ZERO;
               rsp.new_v = neg_sat(req.right_v);
            end
            CODE_S: begin
               rsp.new_u = neg_sat(req.bottom_u);
            end
            CODE_W: begin
               rsp.new_v = neg_sat(req.left_v);
            end
            CODE_NE: begin
               rsp.new_u = VALUE_ZERO;
               rsp.new_v = VALUE_ZERO;
            end
            CODE_SE: begin
               rsp.new_u = VALUE_ZERO;
               rsp.new_v = neg_sat(req.right_v);
            end
            CODE_SW: begin
               rsp.new_u = neg_sat(req.bottom_u);
               rsp.new_v = neg_sat(req.left_v);
            end
            CODE_NW: begin
               rsp.new_u = neg_sat(req.top_u);
               rsp.new_v = VALUE_ZERO;
            end
            CODE_LEFT: begin
               case (kind_left)
                  KIND_NOSLIP: begin
                     rsp.new_u = VALUE_ZERO;
                     rsp.new_v = neg_sat(req.right_v);
                  end
                  KIND_SLIP: begin
                     rsp.new_u = VALUE_ZERO;
                     rsp.new_v = req.right_v;
                  end
                  KIND_OUTFLOW: begin
                     rsp.new_u = req.right_u;
                     rsp.new_v = req.right_v;
                  end
                  KIND_INFLOW: begin
                     rsp.new_u = csr.u_left_wall;
                     rsp.new_v = twice_minus(csr.v_left_wall, req.right_v);
                  end
                  default: begin
                  end
               endcase
            end
            CODE_RIGHT: begin
               case (kind_right) inside
                  KIND_NOSLIP:              rsp.new_v = neg_sat(req.left_v);
                  KIND_SLIP, KIND_OUTFLOW:  rsp.new_v = req.left_v;
                  KIND_INFLOW:              rsp.new_v = twice_minus(csr.v_right_wall,
                                                                    req.left_v);
                  default: begin
                  end
               endcase
            end
            CODE_BOTTOM: begin
               case (kind_bottom)
                  KIND_NOSLIP: begin
                     rsp.new_u = neg_sat(req.top_u);
                     rsp.new_v = VALUE_ZERO;
                  end
                  KIND_SLIP: begin
                     rsp.new_u = req.top_u;
                     rsp.new_v = VALUE_ZERO;
                  end
                  KIND_OUTFLOW: begin
                     rsp.new_u = req.top_u;
                     rsp.new_v = req.top_v;
                  end
                  KIND_INFLOW: begin
                     rsp.new_u = twice_minus(csr.u_bottom_wall, req.top_u);
                     rsp.new_v = csr.v_bottom_wall;
                  end
                  default: begin
                  end
               endcase
            end
            CODE_TOP: begin
               case (kind_top) inside
                  KIND_NOSLIP, KIND_INFLOW: rsp.new_u = twice_minus(csr.u_top_wall,
                                                                    req.bottom_u);
                  KIND_SLIP, KIND_OUTFLOW:  rsp.new_u = req.bottom_u;
                  default: begin
                  end
               endcase
            end
            default: begin
               // unlisted class: keep the middle values
            end
         endcase
      end
   end

endmodule
